/* rtl/itar_pkg.sv */
// Shared types, constants and the digit table of the integer to ASCII converter.
package itar_pkg;

    // Default word width of the converted integer.
    localparam int WORD_BITS_DEF = 32;

    // Division bits resolved in one cycle of the shared divider.
    localparam int DIV_STEPS = 8;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Radix limits and the only radix that shows a sign.
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;
    localparam logic [4:0] RADIX_DEC = 5'd10;

    // Power-of-two radices.
    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_QUA = 5'd4;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // Classified job as it travels from the front to the back part.
    typedef struct packed {
        logic [4:0] radix;
        logic       pow2;
        logic [2:0] shift;
        logic       neg;
    } t_job;

    // Maps a digit value to its ASCII code, 0-9 then uppercase A-F.
    function automatic logic [6:0] digit_char(input logic [3:0] digit);
        logic [6:0] ch;
        unique case (digit)
            4'h0: ch = 7'h30;
            4'h1: ch = 7'h31;
            4'h2: ch = 7'h32;
            4'h3: ch = 7'h33;
            4'h4: ch = 7'h34;
            4'h5: ch = 7'h35;
            4'h6: ch = 7'h36;
            4'h7: ch = 7'h37;
            4'h8: ch = 7'h38;
            4'h9: ch = 7'h39;
            4'hA: ch = 7'h41;
            4'hB: ch = 7'h42;
            4'hC: ch = 7'h43;
            4'hD: ch = 7'h44;
            4'hE: ch = 7'h45;
            4'hF: ch = 7'h46;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/itar_front.sv */
// Front part: accepts a transaction, clamps the radix and splits sign from magnitude.
module itar_front import itar_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_start,
    input  logic                 i_full,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [4:0]           i_base,
    output logic                 o_busy,
    output logic                 o_push,
    output logic [WORD_BITS-1:0] o_mag,
    output t_job                 o_job
);

    logic [4:0] w_radix;
    logic [2:0] w_shift;
    logic       w_neg;

    // Out-of-range radices saturate to the nearest legal one.
    always_comb begin
        priority if (i_base < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (i_base > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end else begin
            w_radix = i_base;
        end
    end

    // Power-of-two radices are handled by plain bit slicing in the back part.
    always_comb begin
        unique case (w_radix)
            RADIX_BIN: w_shift = 3'd1;
            RADIX_QUA: w_shift = 3'd2;
            RADIX_OCT: w_shift = 3'd3;
            RADIX_HEX: w_shift = 3'd4;
            default:   w_shift = 3'd0;
        endcase
    end

    assign w_neg  = (w_radix == RADIX_DEC) && i_value[WORD_BITS-1];
    assign o_mag  = w_neg ? (~i_value + WORD_BITS'(1)) : i_value;
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    assign o_job.radix = w_radix;
    assign o_job.pow2  = (w_shift != 3'd0);
    assign o_job.shift = w_shift;
    assign o_job.neg   = w_neg;

endmodule

/* rtl/itar_fifo.sv */
// Short queue of classified jobs between the front and back parts.
module itar_fifo import itar_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/itar_back.sv */
// Back part: iterative radix conversion into a digit store, then emission MSD first.
module itar_back import itar_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  logic [WORD_BITS-1:0] i_mag,
    input  t_job                 i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [6:0]           o_character,
    output logic                 o_last
);

    localparam int CHUNKS = (WORD_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PADW   = CHUNKS * DIV_STEPS;
    localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IDXW   = $clog2(WORD_BITS);
    localparam int NDW    = $clog2(WORD_BITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_PRIME = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    t_job            r_job, n_job;
    logic [PADW-1:0] r_q, n_q;
    logic [3:0]      r_rem, n_rem;
    logic [CHW-1:0]  r_chunk, n_chunk;
    logic [NDW-1:0]  r_nd, n_nd;
    logic [IDXW-1:0] r_ptr, n_ptr;
    logic [NDW-1:0]  r_left, n_left;
    logic [3:0]      r_rd;

    logic [3:0]      r_digits [WORD_BITS];

    logic [PADW-1:0] w_div_q;
    logic [3:0]      w_div_rem;
    logic [4:0]      w_one;
    logic [3:0]      w_mask;
    logic            w_wr;
    logic [3:0]      w_digit;
    logic            w_rd_en;

    // Long division by the radix, DIV_STEPS quotient bits per cycle, in place.
    always_comb begin
        logic [PADW-1:0] q;
        logic [4:0]      t;
        logic [3:0]      rem;
        q   = r_q;
        rem = r_rem;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {rem, q[PADW-1]};
            q = {q[PADW-2:0], 1'b0};
            if (t >= r_job.radix) begin
                t    = t - r_job.radix;
                q[0] = 1'b1;
            end
            rem = t[3:0];
        end
        w_div_q   = q;
        w_div_rem = rem;
    end

    assign w_one  = 5'd1 << r_job.shift;
    assign w_mask = 4'(w_one - 5'd1);

    assign o_pop = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        logic done;
        done    = 1'b0;
        n_state = r_state;
        n_job   = r_job;
        n_q     = r_q;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_nd    = r_nd;
        n_ptr   = r_ptr;
        n_left  = r_left;
        w_wr    = 1'b0;
        w_digit = '0;
        w_rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_q     = PADW'(i_mag);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_nd    = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_job.pow2) begin
                    w_wr    = 1'b1;
                    w_digit = r_q[3:0] & w_mask;
                    n_q     = r_q >> r_job.shift;
                    done    = (n_q == '0);
                end else begin
                    n_q   = w_div_q;
                    n_rem = w_div_rem;
                    if (r_chunk == CHW'(CHUNKS - 1)) begin
                        w_wr    = 1'b1;
                        w_digit = w_div_rem;
                        n_rem   = '0;
                        n_chunk = '0;
                        done    = (w_div_q == '0);
                    end else begin
                        n_chunk = r_chunk + CHW'(1);
                    end
                end
                if (w_wr) begin
                    n_nd = r_nd + NDW'(1);
                end
                if (done) begin
                    n_ptr   = r_nd[IDXW-1:0];
                    n_left  = r_nd + NDW'(1);
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                w_rd_en = 1'b1;
                n_ptr   = r_ptr - IDXW'(1);
                n_state = r_job.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                w_rd_en = 1'b1;
                n_ptr   = r_ptr - IDXW'(1);
                n_left  = r_left - NDW'(1);
                if (r_left == NDW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_chunk <= n_chunk;
        r_nd    <= n_nd;
        r_ptr   <= n_ptr;
        r_left  <= n_left;
    end

    // Digit store, written least significant digit first and read back downward.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_digits[r_nd[IDXW-1:0]] <= w_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_digits[r_ptr];
        end
    end

    assign o_strobe    = (r_state == ST_SIGN) || (r_state == ST_EMIT);
    assign o_character = (r_state == ST_SIGN) ? CHAR_MINUS : digit_char(r_rd);
    assign o_last      = (r_state == ST_EMIT) && (r_left == NDW'(1));

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("emitting with no digits left");

    a_last_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_strobe)
        else $error("character strobed directly after the last one");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> (r_nd < NDW'(WORD_BITS)))
        else $error("digit store overrun");

    a_sign_only_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> (r_job.neg && (r_job.radix == RADIX_DEC)))
        else $error("sign emitted outside radix ten");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_CONV))
        else $error("popped job did not start conversion");

endmodule

/* rtl/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter for radices 2 to 16.
//
// Usage: a transaction is offered with start high and taken at a rising edge where
// busy is low; i_value and i_base are sampled then. Radices below 2 act as 2 and
// above 16 act as 16. Only radix ten shows negative values, as '-' and magnitude.
// The text comes out on o_character one character per strobed cycle, most
// significant digit first, with o_last on the final character; no terminator.
// The receiver cannot stall: each character is valid for exactly one cycle.
// A two-entry queue sits between the front and back parts, so busy rises only
// when two numbers are waiting behind the one being converted.
// The back part takes a job from the queue, then finds the digits by bit slicing
// in a power-of-two radix, or in any other radix on the shared 8-bit-per-cycle
// divider, then reads the digit store, then emits the characters (a sign first,
// if any). The first character appears in the cycle right after the store read.
// A new job is taken from the queue only after the last character of the one
// before it has come out.
// Reset is synchronous and active low; it empties the queue and idles the back
// part, and any text in flight is dropped.
module integer_to_ascii_radix import itar_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [4:0]           i_base,
    output logic                 o_strobe,
    output logic [6:0]           o_character,
    output logic                 o_last
);

    localparam int JOB_W = $bits(t_job);
    localparam int QW    = WORD_BITS + JOB_W;

    logic                 w_full;
    logic                 w_push;
    logic [WORD_BITS-1:0] w_front_mag;
    t_job                 w_front_job;
    logic                 w_q_valid;
    logic [QW-1:0]        w_q_data;
    logic                 w_pop;
    t_job                 w_back_job;

    // The front part classifies each accepted transaction in the same cycle.
    itar_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .i_start (start),
        .i_full  (w_full),
        .i_value (i_value),
        .i_base  (i_base),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_mag   (w_front_mag),
        .o_job   (w_front_job)
    );

    // Classified jobs wait here while the back part is converting.
    itar_fifo #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_mag, w_front_job}),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_back_job = w_q_data[JOB_W-1:0];

    // The back part converts one job at a time and streams its characters.
    itar_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_mag       (w_q_data[QW-1:JOB_W]),
        .i_job       (w_back_job),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

/* test/tb_integer_to_ascii_radix.sv */
// Self-checking testbench of the integer to ASCII radix converter.
module tb_integer_to_ascii_radix;
    import itar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = WORD_BITS_DEF;

    // The slowest correct transaction in the back part is radix 3 with 21 digits.
    // Roughly 480 numbers, each with a sender gap, stay far below this limit.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to wait after the last expected character, longer than one conversion.
    localparam int TAIL_CYCLES = 150;

    localparam int RANDOM_NUMBERS = 450;
    localparam int MAX_REPORTS = 10;

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;

    // One number waiting to be offered, with the idling it is offered under.
    typedef struct {
        logic [WORD_BITS-1:0] value;
        logic [4:0]           base;
        int unsigned          idle_pct;
        bit                   drain_first;
    } t_number;

    // One character of text that the converter should emit.
    typedef struct {
        logic [6:0] character;
        logic       last;
    } t_text_char;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [WORD_BITS-1:0] i_value = '0;
    logic [4:0]           i_base = RADIX_DEC;
    logic                 o_strobe;
    logic [6:0]           o_character;
    logic                 o_last;

    t_number     pending_numbers[$];
    t_text_char  expected_text[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    integer_to_ascii_radix #(
        .WORD_BITS(WORD_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_value(i_value),
        .i_base(i_base),
        .o_strobe(o_strobe),
        .o_character(o_character),
        .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    // Works out the text of one number and appends it to the expected characters.
    // The radix saturates into 2..16; only radix ten shows a sign, and there the
    // magnitude is the two's complement negation, which for the most negative value
    // wraps to itself and reads correctly as unsigned.
    function automatic void predict_text(input logic [WORD_BITS-1:0] value,
                                         input logic [4:0] base);
        logic [WORD_BITS-1:0] magnitude;
        logic [WORD_BITS-1:0] radix;
        logic [3:0]           digits[WORD_BITS];
        int                   count;
        bit                   negative;
        t_text_char           entry;

        if (base < RADIX_MIN) begin
            radix = RADIX_MIN;
        end else if (base > RADIX_MAX) begin
            radix = RADIX_MAX;
        end else begin
            radix = base;
        end
        negative = (radix == RADIX_DEC) && value[WORD_BITS-1];
        magnitude = negative ? -value : value;

        // Digits are collected least significant first; zero still gives one digit.
        count = 0;
        do begin
            digits[count] = 4'(magnitude % radix);
            count++;
            magnitude = magnitude / radix;
        end while (magnitude != 0);

        if (negative) begin
            entry.character = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        for (int i = count - 1; i >= 0; i--) begin
            if (digits[i] < 10) begin
                entry.character = CHAR_ZERO + 7'(digits[i]);
            end else begin
                entry.character = CHAR_UPPER_A + 7'(digits[i] - 10);
            end
            entry.last = (i == 0);
            expected_text.push_back(entry);
        end
    endfunction

    task automatic add_number(input logic [WORD_BITS-1:0] value, input logic [4:0] base,
                              input int unsigned idle_pct, input bit drain_first);
        pending_numbers.push_back('{value, base, idle_pct, drain_first});
    endtask

    // Driver. A transaction is taken at an edge where start is high and busy is low.
    // Once start is raised it is held until the number is taken, so start and the
    // payload get at most one nonblocking assignment per edge.
    always @(posedge i_clk) begin
        logic offer;
        logic accepted;

        offer = start;
        accepted = start && !busy;
        if (i_rst_n) begin
            if (accepted) begin
                void'(pending_numbers.pop_front());
                offer = 1'b0;
            end
            if (!offer && pending_numbers.size() != 0) begin
                // A marked number waits until all text already owed has come out.
                // The number taken at this very edge has not been predicted yet,
                // so that case also counts as text still owed.
                if (pending_numbers[0].drain_first
                        && (accepted || expected_text.size() != 0)) begin
                    offer = 1'b0;
                end else if ($urandom_range(99) < pending_numbers[0].idle_pct) begin
                    offer = 1'b0;
                end else begin
                    offer = 1'b1;
                    i_value <= pending_numbers[0].value;
                    i_base <= pending_numbers[0].base;
                end
            end
            start <= offer;
        end
    end

    // Monitor. Each strobed character is checked against the oldest expectation,
    // and only then is a number taken at this edge predicted, so the order of the
    // two never depends on the scheduler.
    always @(posedge i_clk) begin
        t_text_char want;

        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected character %h last %b", $realtime,
                                 o_character, o_last);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (o_character !== want.character || o_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: character expected %h last %b, got %h last %b",
                                     $realtime, want.character, want.last,
                                     o_character, o_last);
                        end
                    end
                end
            end
            if (start && !busy) begin
                predict_text(i_value, i_base);
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin
        logic [WORD_BITS-1:0] value;
        logic [4:0]           base;
        int unsigned          idle_pct;

        // Directed part: zero, all ones, the largest and most negative values in
        // the signed and the unsigned radices, then every other radix once, and
        // radices below two and above sixteen, which saturate.
        add_number('0, RADIX_DEC, 0, 1'b0);
        add_number('0, RADIX_BIN, 0, 1'b0);
        add_number('0, RADIX_HEX, 0, 1'b0);
        add_number('1, RADIX_DEC, 0, 1'b0);
        add_number('1, RADIX_BIN, 0, 1'b0);
        add_number('1, RADIX_OCT, 0, 1'b0);
        add_number('1, RADIX_HEX, 0, 1'b0);
        add_number({1'b0, {(WORD_BITS - 1){1'b1}}}, RADIX_DEC, 0, 1'b0);
        add_number({1'b0, {(WORD_BITS - 1){1'b1}}}, RADIX_BIN, 0, 1'b0);
        add_number({1'b1, {(WORD_BITS - 1){1'b0}}}, RADIX_DEC, 0, 1'b0);
        add_number({1'b1, {(WORD_BITS - 1){1'b0}}}, RADIX_HEX, 0, 1'b0);
        add_number({1'b1, {(WORD_BITS - 1){1'b0}}}, RADIX_BIN, 0, 1'b0);
        for (int b = RADIX_MIN + 1; b < RADIX_MAX; b++) begin
            if (b != RADIX_OCT && b != RADIX_DEC) begin
                add_number($urandom, 5'(b), 0, 1'b0);
            end
        end
        add_number(-32'sd1234, 5'd0, 0, 1'b0);
        add_number(32'd37, 5'd1, 0, 1'b0);
        add_number(-32'sd1, 5'd17, 0, 1'b0);
        add_number(32'hDEADBEEF, 5'd31, 0, 1'b0);

        // Random part in four idling phases: none, sender idle most of the time,
        // sender idle about a third of the time, none again. The last number of the first
        // phase and the first of the third phase wait until all owed text has come out.
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            case (n * 4 / RANDOM_NUMBERS)
                1: idle_pct = 81;
                2: idle_pct = 38;
                default: idle_pct = 0;
            endcase
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom_range(300);
                2: value = -WORD_BITS'($urandom_range(1000, 1));
                default: value = $urandom >> $urandom_range(WORD_BITS - 1);
            endcase
            if ($urandom_range(9) == 0) begin
                base = 5'($urandom_range(31));
            end else begin
                base = 5'($urandom_range(RADIX_MAX, RADIX_MIN));
            end
            add_number(value, base, idle_pct,
                       n == RANDOM_NUMBERS / 4 || n == RANDOM_NUMBERS / 2);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample after the edge has settled, so a number taken at this edge is
        // already among the expected characters.
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_numbers.size() != 0 || expected_text.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_integer_to_ascii_radix: clean");
        end else begin
            $display("tb_integer_to_ascii_radix: errors");
        end
        $finish;
    end

    // Watchdog: a hung handshake or missing text ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_integer_to_ascii_radix: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/itar_pkg.sv
rtl/itar_front.sv
rtl/itar_fifo.sv
rtl/itar_back.sv
rtl/integer_to_ascii_radix.sv
test/tb_integer_to_ascii_radix.sv
